>>> rtl/bbr_pkg.sv
// shared types and constants of the horizontal box blur
// no dependencies; imported by every module of the block
package bbr_pkg;

  // stream and window geometry
  localparam int MAX_RADIUS = 48;
  localparam int RING_DEPTH = 128;
  localparam int RADIUS_W   = 6;
  localparam int PIXEL_W    = 32;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 4;
  localparam int POS_W      = 7;
  localparam int SUM_W      = 15;
  localparam int ADDR_W     = $clog2(RING_DEPTH);
  localparam int LEN_W      = RADIUS_W + 1;
  localparam int SPAN_W     = RADIUS_W + 2;

  // radius limits: configured maximum and what the ring can hold
  localparam int RING_RADIUS    = (RING_DEPTH - 1) / 2;
  localparam int EFF_MAX_RADIUS = (MAX_RADIUS < RING_RADIUS) ? MAX_RADIUS : RING_RADIUS;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // reciprocal divider
  localparam int RECIP_SHIFT   = 23;
  localparam int RECIP_W       = RECIP_SHIFT + 1;
  localparam int PROD_W        = SUM_W + RECIP_W;
  localparam int RECIP_ENTRIES = 1 << RADIUS_W;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [PIXEL_W-1:0]  pixel;
    logic                last;
    logic [POS_W-1:0]    pos;
    logic [RADIUS_W-1:0] radius;
    logic [ADDR_W-1:0]   slot;
  } job_t;

  // framing flags that travel with every result
  typedef struct packed {
    logic row_end;
    logic run_last;
  } flags_t;

  typedef logic [NUM_CHAN-1:0][SUM_W-1:0] sums_t;

endpackage

>>> rtl/box_blur_row_filter.sv
// horizontal box blur over an ARGB row stream, top level
// the result for pixel x leaves after the beat of pixel x+r (or the row end) is taken
// throughput: one pixel per cycle unless stalled; a row-end pixel occupies the sum
// engine for r+1 steps; the single ring read port and running-sum register set that rate
// reset: control state cleared, radius register set to 1, pixel ring left uninitialised
module box_blur_row_filter
  import bbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PIXEL_W-1:0]  in_pixel_i,
  input  logic                row_end_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RADIUS_W-1:0] cfg_blur_radius_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIXEL_W-1:0]  out_pixel_o,
  output logic                out_row_end_o,
  output logic                run_last_o
);

  logic                job_valid, job_ready;
  job_t                job;
  logic                q_valid, q_ready;
  job_t                q_job;
  logic                sum_valid, sum_ready;
  sums_t               sums;
  logic [RADIUS_W-1:0] sum_radius;
  flags_t              sum_flags;

  // accept and classify
  bbr_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .in_pixel_i       (in_pixel_i),
    .row_end_i        (row_end_i),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_blur_radius_i(cfg_blur_radius_i),
    .job_valid_o      (job_valid),
    .job_ready_i      (job_ready),
    .job_o            (job)
  );

  // decoupling queue
  bbr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(job_valid),
    .push_ready_o(job_ready),
    .push_data_i (job),
    .pop_valid_o (q_valid),
    .pop_ready_i (q_ready),
    .pop_data_o  (q_job)
  );

  // sliding window sums
  bbr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_valid),
    .job_ready_o (q_ready),
    .job_i       (q_job),
    .sum_valid_o (sum_valid),
    .sum_ready_i (sum_ready),
    .sum_o       (sums),
    .sum_radius_o(sum_radius),
    .sum_flags_o (sum_flags)
  );

  // mean per channel
  bbr_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sum_valid_i  (sum_valid),
    .sum_ready_o  (sum_ready),
    .sum_i        (sums),
    .radius_i     (sum_radius),
    .flags_i      (sum_flags),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_pixel_o  (out_pixel_o),
    .out_row_end_o(out_row_end_o),
    .run_last_o   (run_last_o)
  );

endmodule

>>> rtl/bbr_front.sv
// front end of the box blur: input and config acceptance, row tracking
// builds one job per pixel for the queue; uses bbr_pkg
module bbr_front
  import bbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [PIXEL_W-1:0]  in_pixel_i,
  input  logic                row_end_i,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [RADIUS_W-1:0] cfg_blur_radius_i,
  output logic                job_valid_o,
  input  logic                job_ready_i,
  output job_t                job_o
);

  logic [RADIUS_W-1:0] cfg_radius_q;
  logic [RADIUS_W-1:0] row_radius_q, row_radius_d;
  logic [RADIUS_W-1:0] eff_radius;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [ADDR_W-1:0]   slot_q, slot_d;
  logic                accept;

  // radius clipped to what the window and ring allow
  assign eff_radius = (cfg_radius_q > RADIUS_W'(EFF_MAX_RADIUS)) ?
                      RADIUS_W'(EFF_MAX_RADIUS) : cfg_radius_q;

  // handshake passes straight through to the queue
  assign accept      = in_valid_i && job_ready_i;
  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign cfg_ready_o = 1'b1;

  // radius is latched on the first pixel of a row
  always_comb begin
    row_radius_d = (pos_q == '0) ? eff_radius : row_radius_q;
    slot_d       = slot_q + ADDR_W'(1);
    if (row_end_i) begin
      pos_d = '0;
    end else if (pos_q == '1) begin
      pos_d = pos_q;
    end else begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  // job payload
  always_comb begin
    job_o.pixel  = in_pixel_i;
    job_o.last   = row_end_i;
    job_o.pos    = pos_q;
    job_o.radius = row_radius_d;
    job_o.slot   = slot_q;
  end

  // row state and radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_radius_q <= RADIUS_W'(1);
      row_radius_q <= '0;
      pos_q        <= '0;
      slot_q       <= '0;
    end else begin
      if (cfg_valid_i) begin
        cfg_radius_q <= cfg_blur_radius_i;
      end
      if (accept) begin
        row_radius_q <= row_radius_d;
        pos_q        <= pos_d;
        slot_q       <= slot_d;
      end
    end
  end

endmodule

>>> rtl/bbr_queue.sv
// short job queue between the front end and the sliding-sum engine
// register based; uses bbr_pkg
module bbr_queue
  import bbr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  job_t              entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;
  logic              push, pop;

  assign push_ready_o = (count_q != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop && !push) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/bbr_back.sv
// sliding-sum engine: pixel ring, per-step sequencer and running channel sums
// one step per cycle while the result register can advance, row-end pixels expand into radius+1 steps; uses bbr_pkg
module bbr_back
  import bbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                job_valid_i,
  output logic                job_ready_o,
  input  job_t                job_i,
  output logic                sum_valid_o,
  input  logic                sum_ready_i,
  output sums_t               sum_o,
  output logic [RADIUS_W-1:0] sum_radius_o,
  output flags_t              sum_flags_o
);

  // sequencer
  logic                flushing_q;
  job_t                job_q;
  logic [RADIUS_W-1:0] e_q;
  logic                adv, issue;
  job_t                step_job;
  logic [RADIUS_W-1:0] step_e;
  logic                step_first;
  logic [SPAN_W-1:0]   span;
  logic [POS_W-1:0]    lag;
  logic [ADDR_W-1:0]   rd_addr;
  logic                step_init, step_emit;
  flags_t              step_flags;

  // ring and read port
  logic [PIXEL_W-1:0]  ring_q [RING_DEPTH];
  logic [PIXEL_W-1:0]  rd_data_q;

  // step stage
  logic                s1_valid_q;
  logic [PIXEL_W-1:0]  s1_pixel_q;
  logic                s1_init_q, s1_emit_q;
  flags_t              s1_flags_q;
  logic [RADIUS_W-1:0] s1_radius_q;
  logic [LEN_W-1:0]    s1_len;

  // running sums and result register
  sums_t               acc_q, acc_d;
  logic                sum_valid_q;
  sums_t               sum_q;
  logic [RADIUS_W-1:0] sum_radius_q;
  flags_t              sum_flags_q;

  assign adv         = !sum_valid_q || sum_ready_i;
  assign job_ready_o = adv && !flushing_q;
  assign issue       = adv && (flushing_q || job_valid_i);

  // step selection: a fresh pixel at offset r, or the next flush offset
  always_comb begin
    step_job   = flushing_q ? job_q : job_i;
    step_e     = flushing_q ? e_q : job_i.radius;
    step_first = !flushing_q;
  end

  // oldest pixel leaving the window, clamped to the row start
  always_comb begin
    span    = SPAN_W'(step_e) + SPAN_W'(step_job.radius) + SPAN_W'(1);
    lag     = (span > SPAN_W'(step_job.pos)) ? step_job.pos : POS_W'(span);
    rd_addr = step_job.slot - ADDR_W'(lag);
  end

  // step classification
  always_comb begin
    step_init           = step_first && (step_job.pos == '0);
    step_emit           = (POS_W'(step_e) <= step_job.pos);
    step_flags.row_end  = step_job.last && (step_e == '0);
    step_flags.run_last = !step_job.last || (step_e == '0);
  end

  // flush sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flushing_q <= 1'b0;
    end else if (issue) begin
      if (flushing_q) begin
        if (e_q == '0) begin
          flushing_q <= 1'b0;
        end
      end else if (job_i.last && (job_i.radius != '0)) begin
        flushing_q <= 1'b1;
      end
    end
  end

  // flush offset and held job
  always_ff @(posedge clk_i) begin
    if (issue) begin
      if (flushing_q) begin
        e_q <= e_q - RADIUS_W'(1);
      end else begin
        e_q   <= job_i.radius - RADIUS_W'(1);
        job_q <= job_i;
      end
    end
  end

  // pixel ring: newest written on the first step, registered read
  always_ff @(posedge clk_i) begin
    if (issue && step_first) begin
      ring_q[step_job.slot] <= step_job.pixel;
    end
    if (adv) begin
      rd_data_q <= ring_q[rd_addr];
    end
  end

  // step stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= issue;
    end
  end

  // step stage payload
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pixel_q  <= step_job.pixel;
      s1_init_q   <= step_init;
      s1_emit_q   <= step_emit;
      s1_flags_q  <= step_flags;
      s1_radius_q <= step_job.radius;
    end
  end

  // window update: seed with (2r+1) copies of the first pixel, else slide
  assign s1_len = {s1_radius_q, 1'b1};

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (s1_init_q) begin
        acc_d[c] = SUM_W'(s1_pixel_q[c*CHAN_W +: CHAN_W]) * SUM_W'(s1_len);
      end else begin
        acc_d[c] = acc_q[c] + SUM_W'(s1_pixel_q[c*CHAN_W +: CHAN_W])
                 - SUM_W'(rd_data_q[c*CHAN_W +: CHAN_W]);
      end
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
    end else if (adv) begin
      sum_valid_q <= s1_valid_q && s1_emit_q;
    end
  end

  // running sums and result payload
  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      acc_q        <= acc_d;
      sum_q        <= acc_d;
      sum_radius_q <= s1_radius_q;
      sum_flags_q  <= s1_flags_q;
    end
  end

  assign sum_valid_o  = sum_valid_q;
  assign sum_o        = sum_q;
  assign sum_radius_o = sum_radius_q;
  assign sum_flags_o  = sum_flags_q;

  // a flush only runs for a row-end pixel
  a_flush_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> job_q.last)
    else $error("flush running for a pixel that does not end its row");

  // flush offset stays below the row radius
  a_flush_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing_q |-> (e_q < job_q.radius))
    else $error("flush offset out of range");

  // seeding a row gives a result only at radius zero
  a_seed_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_init_q) |-> (s1_emit_q == (s1_radius_q == '0)))
    else $error("row seed step emitted wrongly");

endmodule

>>> rtl/bbr_div.sv
// per-channel division of window sums by the window length 2r+1
// reciprocal multiply, one-step correction, output register; uses bbr_pkg
module bbr_div
  import bbr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                sum_valid_i,
  output logic                sum_ready_o,
  input  sums_t               sum_i,
  input  logic [RADIUS_W-1:0] radius_i,
  input  flags_t              flags_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [PIXEL_W-1:0]  out_pixel_o,
  output logic                out_row_end_o,
  output logic                run_last_o
);

  logic [RECIP_W-1:0] recip_tab [RECIP_ENTRIES];
  logic               adv;

  // multiply stage
  logic                           a_valid_q;
  logic [NUM_CHAN-1:0][PROD_W-1:0] a_prod_q;
  sums_t                          a_sum_q;
  logic [LEN_W-1:0]               a_len_q;
  flags_t                         a_flags_q;

  // correction and output
  logic [PIXEL_W-1:0] quot;
  logic               out_valid_q;
  logic [PIXEL_W-1:0] out_pixel_q;
  flags_t             out_flags_q;

  // reciprocal table, floor(2^23 / (2r+1))
  for (genvar g = 0; g < RECIP_ENTRIES; g++) begin : g_recip
    localparam logic [RECIP_W-1:0] Recip = RECIP_W'((64'd1 << RECIP_SHIFT) / (2 * g + 1));
    assign recip_tab[g] = Recip;
  end

  assign adv         = !out_valid_q || out_ready_i;
  assign sum_ready_o = adv;

  // multiply stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= sum_valid_i;
    end
  end

  // quotient estimate, never more than one below the true value
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        a_prod_q[c] <= PROD_W'(sum_i[c]) * PROD_W'(recip_tab[radius_i]);
      end
      a_sum_q   <= sum_i;
      a_len_q   <= {radius_i, 1'b1};
      a_flags_q <= flags_i;
    end
  end

  // correction: bump the estimate when the remainder reaches the divisor
  always_comb begin
    logic [CHAN_W-1:0] est;
    logic [SUM_W-1:0]  rem;
    for (int c = 0; c < NUM_CHAN; c++) begin
      est = a_prod_q[c][RECIP_SHIFT +: CHAN_W];
      rem = a_sum_q[c] - SUM_W'(est) * SUM_W'(a_len_q);
      quot[c*CHAN_W +: CHAN_W] = est + CHAN_W'(rem >= SUM_W'(a_len_q));
    end
  end

  // output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= a_valid_q;
    end
  end

  // output beat
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_pixel_q <= quot;
      out_flags_q <= a_flags_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_pixel_o   = out_pixel_q;
  assign out_row_end_o = out_flags_q.row_end;
  assign run_last_o    = out_flags_q.run_last;

endmodule
